// ----- rtl/sha1bh_pkg.sv -----
`default_nettype none

package sha1bh_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAIN_WORDS = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int GROUP_LEN   = 20;
    localparam int COUNT_W     = $clog2(BLOCK_WORDS);
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int INDEX_W     = 3;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t INIT_CHAIN [CHAIN_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_GROUP0 = 32'h5A827999;
    localparam word_t K_GROUP1 = 32'h6ED9EBA1;
    localparam word_t K_GROUP2 = 32'h8F1BBCDC;
    localparam word_t K_GROUP3 = 32'hCA62C1D6;

    typedef enum logic [1:0] {
        GRP_CHOOSE  = 2'd0,
        GRP_PARITY  = 2'd1,
        GRP_MAJORITY = 2'd2,
        GRP_PARITY_LATE = 2'd3
    } round_group_t;

    typedef struct packed {
        logic [31:0] message_word;
        logic        start_of_message;
        logic        end_of_message;
    } sha1bh_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        last_word;
    } sha1bh_out_t;

    // controller -> datapath
    typedef struct packed {
        logic         shift_in;     // accepted beat: push word into schedule
        logic         load_init;    // reload initial chain
        logic         init_work;    // copy chain into working vars
        logic         round_en;     // run one round
        logic         expand;       // schedule word comes from expansion
        round_group_t group;
        logic         chain_add;    // fold working vars into chain
        logic         load_digest;  // copy chain into output buffer
    } sha1bh_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
    } sha1bh_sts_t;

    function automatic word_t round_f(round_group_t g, word_t b, word_t c, word_t d);
        word_t r;
        case (g)
            GRP_CHOOSE:   r = d ^ (b & (c ^ d));
            GRP_MAJORITY: r = (b & c) | ((b | c) & d);
            default:      r = b ^ c ^ d;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(round_group_t g);
        word_t r;
        case (g)
            GRP_CHOOSE:   r = K_GROUP0;
            GRP_PARITY:   r = K_GROUP1;
            GRP_MAJORITY: r = K_GROUP2;
            default:      r = K_GROUP3;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sha1bh_ctrl.sv -----
`default_nettype none

module sha1bh_ctrl
    import sha1bh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        start_of_message,
    input  wire logic        end_of_message,
    input  wire sha1bh_sts_t sts,
    output sha1bh_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_ROUND = 4'b0010,
        S_FINAL = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic                 end_reg, end_next;
    logic [COUNT_W-1:0]   count_eff;
    logic                 accept;
    logic                 block_done;

    assign s_ready    = (state_reg == S_LOAD);
    assign accept     = s_valid && s_ready;
    assign count_eff  = start_of_message ? '0 : count_reg;
    assign block_done = accept && (count_eff == COUNT_W'(BLOCK_WORDS - 1));

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        round_next = round_reg;
        end_next   = end_reg;

        cmd             = '0;
        cmd.shift_in    = accept;
        cmd.load_init   = accept && start_of_message;
        cmd.init_work   = block_done;
        cmd.expand      = (round_reg >= ROUND_W'(BLOCK_WORDS));
        if (round_reg < ROUND_W'(GROUP_LEN)) begin
            cmd.group = GRP_CHOOSE;
        end else if (round_reg < ROUND_W'(2 * GROUP_LEN)) begin
            cmd.group = GRP_PARITY;
        end else if (round_reg < ROUND_W'(3 * GROUP_LEN)) begin
            cmd.group = GRP_MAJORITY;
        end else begin
            cmd.group = GRP_PARITY_LATE;
        end

        case (state_reg)
            S_LOAD: begin
                if (accept) begin
                    count_next = count_eff + COUNT_W'(1);
                end
                if (block_done) begin
                    end_next   = end_of_message;
                    round_next = '0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + ROUND_W'(1);
                if (round_reg == ROUND_W'(ROUNDS - 1)) begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                cmd.chain_add = 1'b1;
                state_next    = end_reg ? S_EMIT : S_LOAD;
            end
            S_EMIT: begin
                // wait for the previous digest to drain
                if (!sts.out_busy) begin
                    cmd.load_digest = 1'b1;
                    state_next      = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            round_reg <= '0;
            end_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            end_reg   <= end_next;
        end
    end

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND) |-> (round_reg < ROUND_W'(ROUNDS)))
        else $error("round counter out of range");

    a_block_starts_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.init_work |=> (state_reg == S_ROUND) && (round_reg == '0))
        else $error("block end did not start compression");

    a_single_add: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.chain_add |=> !cmd.chain_add && !cmd.round_en)
        else $error("chain add repeated");

    a_digest_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_digest |-> !sts.out_busy && end_reg)
        else $error("digest load while buffer busy");
`endif

endmodule

`default_nettype wire

// ----- rtl/sha1bh_dpath.sv -----
`default_nettype none

module sha1bh_dpath
    import sha1bh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire sha1bh_cmd_t cmd,
    output sha1bh_sts_t      sts,
    input  wire word_t       message_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output sha1bh_out_t      m_data
);

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(CHAIN_WORDS - 1);

    word_t               win_reg   [BLOCK_WORDS];
    word_t               chain_reg [CHAIN_WORDS];
    word_t               work_reg  [CHAIN_WORDS];
    word_t               dig_reg   [CHAIN_WORDS];
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_idx_reg;

    word_t w_mix;
    word_t w_exp;
    word_t w_t;
    word_t w_push;
    word_t temp;
    logic  out_beat;

    // window holds the last sixteen schedule words, oldest at index 0
    assign w_mix  = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_exp  = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};
    assign w_t    = cmd.expand ? w_exp : win_reg[0];
    assign w_push = cmd.shift_in ? message_word : w_t;

    assign temp = {work_reg[0][WORD_W-6:0], work_reg[0][WORD_W-1:WORD_W-5]}
                + round_f(cmd.group, work_reg[1], work_reg[2], work_reg[3])
                + work_reg[4] + round_k(cmd.group) + w_t;

    always_ff @(posedge aclk) begin
        if (cmd.shift_in || cmd.round_en) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BLOCK_WORDS-1] <= w_push;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init_work) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                work_reg[i] <= chain_reg[i];
            end
        end else if (cmd.round_en) begin
            work_reg[0] <= temp;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][WORD_W-1:2]};
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_init) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                chain_reg[i] <= INIT_CHAIN[i];
            end
        end else if (cmd.chain_add) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
    end

    // output buffer: shifts one digest word out per beat
    assign out_beat = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_digest) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                dig_reg[i] <= chain_reg[i];
            end
        end else if (out_beat) begin
            for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
                dig_reg[i] <= dig_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end else if (cmd.load_digest) begin
            out_valid_reg <= 1'b1;
            out_idx_reg   <= '0;
        end else if (out_beat) begin
            out_idx_reg <= out_idx_reg + INDEX_W'(1);
            if (out_idx_reg == LAST_INDEX) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_data.digest_word  = dig_reg[0];
    assign m_data.digest_index = out_idx_reg;
    assign m_data.last_word    = (out_idx_reg == LAST_INDEX);
    assign sts.out_busy        = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/sha1_block_hash.sv -----
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  sha1bh_in_t  (message word, start, end flags)
// m_       out        m_valid / m_ready  sha1bh_out_t (digest word, index, last flag)
//
// Words are taken one per cycle while s_ready is high; the sixteenth word of a block
// holds off s_ready while the 80 rounds run on the single round unit and the chain
// add follows, and on a block that ends a message also through the digest hand-off,
// which waits for the output buffer to be free.
// A digest drains from its own buffer, so the next message loads while it waits;
// only a second digest stalls until the first is fully taken.
// aresetn is synchronous, active low; it restores the initial chain value.

`default_nettype none

module sha1_block_hash
    import sha1bh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire sha1bh_in_t  s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output sha1bh_out_t      m_data
);

    sha1bh_cmd_t cmd;
    sha1bh_sts_t sts;

    sha1bh_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .start_of_message (s_data.start_of_message),
        .end_of_message   (s_data.end_of_message),
        .sts              (sts),
        .cmd              (cmd)
    );

    sha1bh_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .message_word (s_data.message_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

`default_nettype wire
